/* rtl/gdoc_pkg.sv */
// Shared constants, types and register codes of the grid disk occupancy checker.
package gdoc_pkg;

  localparam int GRID_DIM_MAX = 4096;
  localparam int FRAC_BITS    = 16;

  localparam int VALUE_W = 8;
  localparam int INDEX_W = 12;
  localparam int COORD_W = 32;
  localparam int RADIUS_W = 31;
  localparam int LEVEL_W = 7;
  localparam int FRAC_W  = FRAC_BITS + 1;
  localparam int CNT_W   = 25;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Product of an axis index term and the cell size, and the signed difference.
  localparam int POS_W  = INDEX_W + 1 + COORD_W;
  localparam int DIFF_W = POS_W + 2;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int PROD_W = CNT_W + FRAC_W;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_CELL_SIZE    = 3'd2,
    CFG_DISK_RADIUS  = 3'd3,
    CFG_LETHAL_LEVEL = 3'd4,
    CFG_MAX_FRACTION = 3'd5,
    CFG_MIN_OBSERVED = 3'd6
  } gdoc_cfg_idx_t;

  // Register values as the datapath uses them, with out-of-range settings clamped.
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        cell_size;
    logic [RADIUS_W-1:0]       disk_radius;
    logic [LEVEL_W-1:0]        lethal_level;
    logic [FRAC_W-1:0]         max_fraction;
    logic [CNT_W-1:0]          min_observed;
  } gdoc_cfg_t;

  // Classified request handed from the front to the counters.
  typedef struct packed {
    logic observed;
    logic lethal;
    logic last;
  } gdoc_tag_t;

endpackage

/* rtl/gdoc_if.sv */
// Valid/ready channel interfaces for cell requests and region results.
interface gdoc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gdoc_pkg::VALUE_W-1:0] cell_value;
  logic [gdoc_pkg::INDEX_W-1:0]        cell_col;
  logic [gdoc_pkg::INDEX_W-1:0]        cell_row;
  logic                                last_cell;

  modport source (output valid, cell_value, cell_col, cell_row, last_cell, input ready);
  modport sink   (input valid, cell_value, cell_col, cell_row, last_cell, output ready);
endinterface

interface gdoc_out_if;
  logic                         valid;
  logic                         ready;
  logic [gdoc_pkg::CNT_W-1:0]   observed_count;
  logic [gdoc_pkg::CNT_W-1:0]   lethal_count;
  logic                         region_clear;

  modport source (output valid, observed_count, lethal_count, region_clear, input ready);
  modport sink   (input valid, observed_count, lethal_count, region_clear, output ready);
endinterface

/* rtl/gdoc_cfg.sv */
// Configuration register file with clamping of out-of-range settings.
module gdoc_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gdoc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gdoc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output gdoc_pkg::gdoc_cfg_t                  cfg
);
  import gdoc_pkg::*;

  logic [COORD_W-1:0]  center_x_r;
  logic [COORD_W-1:0]  center_y_r;
  logic [COORD_W-1:0]  cell_size_r;
  logic [RADIUS_W-1:0] disk_radius_r;
  logic [LEVEL_W-1:0]  lethal_level_r;
  logic [FRAC_W-1:0]   max_fraction_r;
  logic [CNT_W-1:0]    min_observed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      cell_size_r    <= COORD_W'(3277);
      disk_radius_r  <= RADIUS_W'(19661);
      lethal_level_r <= LEVEL_W'(100);
      max_fraction_r <= FRAC_W'(9830);
      min_observed_r <= CNT_W'(8);
    end else if (cfg_we) begin
      unique case (gdoc_cfg_idx_t'(cfg_index))
        CFG_CENTER_X:     center_x_r     <= cfg_wdata[COORD_W-1:0];
        CFG_CENTER_Y:     center_y_r     <= cfg_wdata[COORD_W-1:0];
        CFG_CELL_SIZE:    cell_size_r    <= cfg_wdata[COORD_W-1:0];
        CFG_DISK_RADIUS:  disk_radius_r  <= cfg_wdata[RADIUS_W-1:0];
        CFG_LETHAL_LEVEL: lethal_level_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_MAX_FRACTION: max_fraction_r <= cfg_wdata[FRAC_W-1:0];
        CFG_MIN_OBSERVED: min_observed_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.center_x     = $signed(center_x_r);
    cfg.center_y     = $signed(center_y_r);
    cfg.cell_size    = cell_size_r;
    cfg.disk_radius  = disk_radius_r;
    cfg.lethal_level = (lethal_level_r > LEVEL_MAX) ? LEVEL_MAX : lethal_level_r;
    cfg.max_fraction = (max_fraction_r > FRAC_ONE) ? FRAC_ONE : max_fraction_r;
    cfg.min_observed = (min_observed_r == '0) ? CNT_W'(1) : min_observed_r;
  end

endmodule

/* rtl/gdoc_front.sv */
// Front end: accepts cell requests and classifies them through a three-stage disk test.
module gdoc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gdoc_pkg::gdoc_cfg_t          cfg,
  gdoc_in_if.sink                      in_req,
  input  logic [gdoc_pkg::QCNT_W-1:0]  q_count,
  output logic                         push,
  output gdoc_pkg::gdoc_tag_t          push_tag
);
  import gdoc_pkg::*;

  logic               accept;
  logic [QCNT_W:0]    occupancy;

  // Stage 1: axis positions of the cell center at twice the Q16.16 scale.
  logic               v1_r, last1_r, known1_r, leth1_r;
  logic [POS_W-1:0]   wx1_r, wy1_r;
  // Stage 2: axis distances, with a flag set when both lie within the radius.
  logic               v2_r, last2_r, known2_r, leth2_r, near2_r;
  logic [COORD_W-1:0] dx2_r, dy2_r;
  // Stage 3: squared distances.
  logic               v3_r, last3_r, known3_r, leth3_r;
  logic [SQ_W-1:0]    sx3_r, sy3_r;

  logic [COORD_W-1:0] radius2;
  logic [SQ_W-1:0]    rr_r;
  logic               known_in, leth_in;
  logic signed [DIFF_W-1:0] ddx, ddy;
  logic [DIFF_W-1:0]  adx, ady;
  logic               near_nxt;
  logic [SQ_W:0]      dist_sq;
  logic               hit;

  // The queue and the stages together never hold more than the queue depth, so
  // every request in flight is sure of a queue slot.
  assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r)
                   + (QCNT_W+1)'(v3_r);
  assign in_req.ready = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept = in_req.valid && in_req.ready;

  assign radius2 = {cfg.disk_radius, 1'b0};

  always_comb begin
    known_in = !in_req.cell_value[VALUE_W-1]
            && (32'(in_req.cell_col) < 32'(GRID_DIM_MAX))
            && (32'(in_req.cell_row) < 32'(GRID_DIM_MAX));
    leth_in  = in_req.cell_value[LEVEL_W-1:0] >= cfg.lethal_level;

    // The doubled disk center is signed and must be sign extended.
    ddx = $signed({2'b00, wx1_r}) - DIFF_W'($signed({cfg.center_x, 1'b0}));
    ddy = $signed({2'b00, wy1_r}) - DIFF_W'($signed({cfg.center_y, 1'b0}));
    adx = ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
    ady = ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
    near_nxt = (adx <= DIFF_W'(radius2)) && (ady <= DIFF_W'(radius2));

    dist_sq = (SQ_W+1)'(sx3_r) + (SQ_W+1)'(sy3_r);
    hit     = dist_sq <= (SQ_W+1)'(rr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= SQ_W'(radius2) * SQ_W'(radius2);

    last1_r  <= in_req.last_cell;
    known1_r <= known_in;
    leth1_r  <= leth_in;
    wx1_r    <= POS_W'({in_req.cell_col, 1'b1}) * POS_W'(cfg.cell_size);
    wy1_r    <= POS_W'({in_req.cell_row, 1'b1}) * POS_W'(cfg.cell_size);

    last2_r  <= last1_r;
    known2_r <= known1_r;
    leth2_r  <= leth1_r;
    near2_r  <= near_nxt;
    dx2_r    <= adx[COORD_W-1:0];
    dy2_r    <= ady[COORD_W-1:0];

    last3_r  <= last2_r;
    known3_r <= known2_r && near2_r;
    leth3_r  <= leth2_r;
    sx3_r    <= SQ_W'(dx2_r) * SQ_W'(dx2_r);
    sy3_r    <= SQ_W'(dy2_r) * SQ_W'(dy2_r);
  end

  assign push              = v3_r;
  assign push_tag.observed = known3_r && hit;
  assign push_tag.lethal   = known3_r && hit && leth3_r;
  assign push_tag.last     = last3_r;

endmodule

/* rtl/gdoc_fifo.sv */
// Short queue of classified requests between the front end and the counters.
module gdoc_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  gdoc_pkg::gdoc_tag_t          push_tag,
  input  logic                         pop,
  output logic                         q_valid,
  output gdoc_pkg::gdoc_tag_t          q_tag,
  output logic [gdoc_pkg::QCNT_W-1:0]  q_count
);
  import gdoc_pkg::*;

  gdoc_tag_t         slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign q_valid = count_r != '0;
  assign q_tag   = slots_r[rd_ptr_r];
  assign q_count = count_r;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_tag;
  end

endmodule

/* rtl/gdoc_back.sv */
// Back end: saturating counters, region verdict and the result register.
module gdoc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gdoc_pkg::gdoc_cfg_t  cfg,
  input  logic                 q_valid,
  input  gdoc_pkg::gdoc_tag_t  q_tag,
  output logic                 pop,
  gdoc_out_if.source           out_res
);
  import gdoc_pkg::*;

  logic [CNT_W-1:0]  obs_acc_r, leth_acc_r;
  logic [CNT_W-1:0]  obs_upd, leth_upd;

  // Final counts of a grid, then the fraction product, then the result.
  logic              f_valid_r;
  logic [CNT_W-1:0]  f_obs_r, f_leth_r;
  logic              p_valid_r;
  logic [CNT_W-1:0]  p_obs_r, p_leth_r;
  logic [PROD_W-1:0] p_prod_r;
  logic              p_enough_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_obs_r, out_leth_r;
  logic              out_clear_r;

  logic              out_load, p_free, f_free, p_load;
  logic [PROD_W-1:0] leth_scaled;

  assign out_load = p_valid_r && (!out_valid_r || out_res.ready);
  assign p_free   = !p_valid_r || out_load;
  assign p_load   = f_valid_r && p_free;
  assign f_free   = !f_valid_r || p_free;
  // A closing request waits until the final-count stage can take its totals.
  assign pop      = q_valid && (!q_tag.last || f_free);

  assign obs_upd  = (q_tag.observed && obs_acc_r != CNT_MAX) ? obs_acc_r + CNT_W'(1)
                                                              : obs_acc_r;
  assign leth_upd = (q_tag.lethal && leth_acc_r != CNT_MAX) ? leth_acc_r + CNT_W'(1)
                                                             : leth_acc_r;
  assign leth_scaled = PROD_W'(p_leth_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_acc_r   <= '0;
      leth_acc_r  <= '0;
      f_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        obs_acc_r  <= q_tag.last ? '0 : obs_upd;
        leth_acc_r <= q_tag.last ? '0 : leth_upd;
      end
      if (pop && q_tag.last) f_valid_r <= 1'b1;
      else if (p_load) f_valid_r <= 1'b0;
      if (p_load) p_valid_r <= 1'b1;
      else if (out_load) p_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_tag.last) begin
      f_obs_r  <= obs_upd;
      f_leth_r <= leth_upd;
    end
    if (p_load) begin
      p_obs_r    <= f_obs_r;
      p_leth_r   <= f_leth_r;
      p_prod_r   <= PROD_W'(cfg.max_fraction) * PROD_W'(f_obs_r);
      p_enough_r <= f_obs_r >= cfg.min_observed;
    end
    if (out_load) begin
      out_obs_r   <= p_obs_r;
      out_leth_r  <= p_leth_r;
      out_clear_r <= p_enough_r && (leth_scaled <= p_prod_r);
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.observed_count = out_obs_r;
  assign out_res.lethal_count   = out_leth_r;
  assign out_res.region_clear   = out_clear_r;

endmodule

/* rtl/grid_disk_occupancy_check.sv */
// Top level of the grid disk occupancy checker.
//
//   channel   direction  carries
//   in_req    sink       cell_value, cell_col, cell_row, last_cell
//   out_res   source     observed_count, lethal_count, region_clear
//   cfg_*     write      seven registers, index 0 to 6, 32-bit data
//
// One cell request is taken per cycle while there is room. The disk test runs in
// three stages (position multiply, distance and bound, squares), then an
// eight-entry queue feeds the counters, which retire one request per cycle
// unless stalled. A result passes the final-count, product and result
// registers. Reset is synchronous: counters and queue clear, registers take
// defaults. A stalled result holds the counters only at a closing request
// finding the final-count stage full; intake stops when queue and stages fill.
module grid_disk_occupancy_check (
  input  logic                                clk,
  input  logic                                rst_n,
  gdoc_in_if.sink                             in_req,
  gdoc_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [gdoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gdoc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gdoc_pkg::*;

  gdoc_cfg_t         cfg;
  logic              push, pop, q_valid;
  gdoc_tag_t         push_tag, q_tag;
  logic [QCNT_W-1:0] q_count;

  gdoc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gdoc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_req   (in_req),
    .q_count  (q_count),
    .push     (push),
    .push_tag (push_tag)
  );

  gdoc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tag (push_tag),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tag    (q_tag),
    .q_count  (q_count)
  );

  gdoc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_tag   (q_tag),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the grid disk occupancy checker, with its own region counter.
module testbench;
  import gdoc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] observed;
    logic [CNT_W-1:0] lethal;
    logic             clear;
  } region_report_t;

  localparam int RANDOM_CELLS = 550;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gdoc_in_if  in_req ();
  gdoc_out_if out_res ();

  grid_disk_occupancy_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req.sink),
    .out_res   (out_res.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gdoc_cfg_t        live_setup;
  logic [CNT_W-1:0] observed_tally;
  logic [CNT_W-1:0] lethal_tally;
  region_report_t   pending_reports[$];
  int               mismatch_cnt = 0;
  int               cells_sent = 0;
  bit               steady_io = 1'b0;
  int               sink_stall = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_io || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Cell centers are compared at twice the register scale, where they are exact integers.
  function automatic logic cell_in_disk(logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row);
    logic signed [63:0] off_x, off_y;
    logic [63:0]        ax, ay;
    logic [127:0]       reach;
    off_x = $signed(64'({col, 1'b1}) * 64'(live_setup.cell_size))
            - 2 * 64'($signed(live_setup.center_x));
    off_y = $signed(64'({row, 1'b1}) * 64'(live_setup.cell_size))
            - 2 * 64'($signed(live_setup.center_y));
    ax = (off_x < 0) ? -off_x : off_x;
    ay = (off_y < 0) ? -off_y : off_y;
    reach = 128'({live_setup.disk_radius, 1'b0});
    return 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) <= reach * reach;
  endfunction

  function automatic void tally_cell(logic signed [VALUE_W-1:0] value,
                                     logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row,
                                     logic last);
    logic [LEVEL_W-1:0] level;
    logic [FRAC_W-1:0]  frac;
    logic [CNT_W-1:0]   min_obs;
    region_report_t     rep;
    level = (live_setup.lethal_level > LEVEL_MAX) ? LEVEL_MAX : live_setup.lethal_level;
    if (value >= 0 && cell_in_disk(col, row)) begin
      if (observed_tally != CNT_MAX) observed_tally++;
      if (unsigned'(value) >= 8'(level) && lethal_tally != CNT_MAX) lethal_tally++;
    end
    if (last) begin
      frac = (live_setup.max_fraction > FRAC_ONE) ? FRAC_ONE : live_setup.max_fraction;
      min_obs = (live_setup.min_observed == '0) ? CNT_W'(1) : live_setup.min_observed;
      rep.observed = observed_tally;
      rep.lethal = lethal_tally;
      rep.clear = (observed_tally >= min_obs) &&
                  ((64'(lethal_tally) << FRAC_BITS) <= 64'(frac) * 64'(observed_tally));
      pending_reports.push_back(rep);
      observed_tally = '0;
      lethal_tally = '0;
    end
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_cell(input logic signed [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] col, input logic [INDEX_W-1:0] row,
                           input logic last);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.cell_value <= value;
    in_req.cell_col <= col;
    in_req.cell_row <= row;
    in_req.last_cell <= last;
    do @(posedge clk); while (!in_req.ready);
    tally_cell(value, col, row, last);
    cells_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input gdoc_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Narrow registers sometimes get junk above their width, which must be dropped.
  task automatic program_regs(input gdoc_cfg_t s);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    put_reg(CFG_CENTER_X, s.center_x);
    put_reg(CFG_CENTER_Y, s.center_y);
    put_reg(CFG_CELL_SIZE, s.cell_size);
    put_reg(CFG_DISK_RADIUS, 32'(s.disk_radius) | (junk << RADIUS_W));
    put_reg(CFG_LETHAL_LEVEL, 32'(s.lethal_level) | (junk << LEVEL_W));
    put_reg(CFG_MAX_FRACTION, 32'(s.max_fraction) | (junk << FRAC_W));
    put_reg(CFG_MIN_OBSERVED, 32'(s.min_observed) | (junk << CNT_W));
    @(negedge clk);
    cfg_we <= 1'b0;
    live_setup = s;
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 8'($urandom_range(128, 255));
    if (roll < 25) return 8'($urandom);
    if (roll < 32) return 8'($urandom_range(101, 127));
    return 8'($urandom_range(0, 100));
  endfunction

  function automatic int place(int centre, int span, int reach);
    int base;
    base = centre - $urandom_range(0, span + reach);
    if (base < 0) base = 0;
    if (base > GRID_DIM_MAX - span) base = GRID_DIM_MAX - span;
    return base;
  endfunction

  task automatic roll_setup(output gdoc_cfg_t s, output int cx, output int cy,
                            output int reach);
    logic [63:0] pitch;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) pitch = $urandom_range(1, 1 << 19);
    else if (roll < 9) pitch = $urandom_range(1, 64);
    else pitch = $urandom;
    cx = $urandom_range(0, GRID_DIM_MAX - 1);
    cy = $urandom_range(0, GRID_DIM_MAX - 1);
    reach = $urandom_range(0, 4);
    s.cell_size = 32'(pitch);
    s.center_x = 32'(64'(cx) * pitch + $urandom_range(0, 32'(pitch)));
    s.center_y = 32'(64'(cy) * pitch + $urandom_range(0, 32'(pitch)));
    s.disk_radius = RADIUS_W'(64'(reach) * pitch + $urandom_range(0, 32'(pitch)));
    if ($urandom_range(0, 9) == 0) begin
      s.center_x = $urandom;
      s.disk_radius = RADIUS_W'($urandom);
    end
    s.lethal_level = LEVEL_W'($urandom_range(0, 127));
    s.max_fraction = ($urandom_range(0, 4) == 0) ? FRAC_W'($urandom)
                                                : FRAC_W'($urandom_range(0, 65536));
    s.min_observed = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom)
                                                : CNT_W'($urandom_range(0, 12));
  endtask

  task automatic test_reset_settings();
    send_cell(8'sh80, 12'd0, 12'd0, 1'b0);
    send_cell(8'sd127, 12'd0, 12'd0, 1'b0);
    send_cell(8'sd0, 12'd5, 12'd0, 1'b0);
    send_cell(8'sd100, 12'd0, 12'd5, 1'b0);
    send_cell(8'sd50, 12'd6, 12'd0, 1'b0);
    send_cell(8'sd99, 12'd3, 12'd3, 1'b0);
    send_cell(8'sd1, 12'd4095, 12'd4095, 1'b1);
    // A grid that sees nothing must not be declared clear.
    send_cell(8'sd5, 12'd4095, 12'd0, 1'b1);
  endtask

  // Center at half a cell, so cells three away sit exactly on the rim.
  task automatic test_disk_rim();
    gdoc_cfg_t s;
    s.center_x = 32'sd32768;
    s.center_y = 32'sd32768;
    s.cell_size = 32'd65536;
    s.disk_radius = 31'd196608;
    s.lethal_level = 7'd127;
    s.max_fraction = 17'h1FFFF;
    s.min_observed = '0;
    program_regs(s);
    send_cell(8'sd100, 12'd3, 12'd0, 1'b0);
    send_cell(8'sd100, 12'd4, 12'd0, 1'b0);
    send_cell(8'sd127, 12'd0, 12'd3, 1'b0);
    send_cell(8'sd64, 12'd2, 12'd2, 1'b0);
    send_cell(8'sd10, 12'd3, 12'd1, 1'b1);
  endtask

  task automatic test_zero_cell_size();
    gdoc_cfg_t s;
    s.center_x = '0;
    s.center_y = '0;
    s.cell_size = '0;
    s.disk_radius = '0;
    s.lethal_level = '0;
    s.max_fraction = '0;
    s.min_observed = CNT_MAX;
    program_regs(s);
    send_cell(8'sd0, 12'd4095, 12'd4095, 1'b0);
    send_cell(8'sd127, 12'd17, 12'd2000, 1'b0);
    send_cell(8'shFF, 12'd0, 12'd0, 1'b1);
  endtask

  task automatic test_coordinate_extremes();
    gdoc_cfg_t s;
    s.center_x = 32'sh8000_0000;
    s.center_y = 32'sh7FFF_FFFF;
    s.cell_size = 32'hFFFF_FFFF;
    s.disk_radius = 31'h7FFF_FFFF;
    s.lethal_level = 7'd1;
    s.max_fraction = FRAC_ONE;
    s.min_observed = CNT_W'(1);
    program_regs(s);
    send_cell(8'sd1, 12'd0, 12'd0, 1'b0);
    send_cell(8'sd0, 12'd0, 12'd4095, 1'b0);
    send_cell(8'sd2, 12'd4095, 12'd0, 1'b0);
    send_cell(8'sd90, 12'd2047, 12'd2048, 1'b1);
  endtask

  task automatic test_random_grids();
    gdoc_cfg_t s;
    int cx, cy, reach, w, h, c0, r0, n, phase, target;
    phase = 0;
    target = cells_sent + RANDOM_CELLS;
    while (cells_sent < target) begin
      roll_setup(s, cx, cy, reach);
      program_regs(s);
      steady_io = (phase == 2);
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 6) == 0) begin
          // Scattered cells anywhere in the grid, mostly far from the disk.
          n = $urandom_range(1, 6);
          for (int k = 0; k < n; k++)
            send_cell(rand_value(), INDEX_W'($urandom), INDEX_W'($urandom), k == n - 1);
        end else begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
          c0 = place(cx, w, reach);
          r0 = place(cy, h, reach);
          for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
              send_cell(rand_value(), INDEX_W'(c0 + c), INDEX_W'(r0 + r),
                        r == h - 1 && c == w - 1);
        end
      end
      steady_io = 1'b0;
      phase++;
    end
  endtask

  task automatic log_mismatch(input string what, input longint want, input longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  initial begin : result_sink
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        out_res.ready <= 1'b0;
        sink_stall--;
      end else begin
        out_res.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_stall = idle_len();
      end
    end
  end

  always @(posedge clk) begin : report_check
    region_report_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_reports.size() == 0) begin
        log_mismatch("unrequested report, observed_count", 0, out_res.observed_count);
      end else begin
        want = pending_reports.pop_front();
        if (want.observed !== out_res.observed_count)
          log_mismatch("observed_count", want.observed, out_res.observed_count);
        if (want.lethal !== out_res.lethal_count)
          log_mismatch("lethal_count", want.lethal, out_res.lethal_count);
        if (want.clear !== out_res.region_clear)
          log_mismatch("region_clear", want.clear, out_res.region_clear);
      end
    end
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.cell_value = '0;
    in_req.cell_col = '0;
    in_req.cell_row = '0;
    in_req.last_cell = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    live_setup.center_x = '0;
    live_setup.center_y = '0;
    live_setup.cell_size = 32'd3277;
    live_setup.disk_radius = 31'd19661;
    live_setup.lethal_level = 7'd100;
    live_setup.max_fraction = 17'd9830;
    live_setup.min_observed = 25'd8;
    observed_tally = '0;
    lethal_tally = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_disk_rim();
    test_zero_cell_size();
    test_coordinate_extremes();
    test_random_grids();

    wait_drained();
    if (pending_reports.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
